// ===== hdl/lzx_pkg.sv =====
// Shared types and constants for the LZX-style bit reader.
// No dependencies; imported by every module of the block.
`default_nettype none

package lzx_pkg;

   localparam int QUEUE_DEPTH = 4;                       // stream words held ahead of the window
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);  // queue fill count width
   localparam int WINDOW_BITS = 8 * 4;
   localparam int SMALL_MAX   = 17;
   localparam int HALF_BITS   = 16;
   localparam int POS_W       = 6;                        // consumed-bit position, 0..32
   localparam int MAX_POPS    = 4;                        // head taps visible to the datapath
   localparam int POP_W       = 3;
   localparam int HEAD_W      = 2;

   typedef enum logic [2:0] {
      ACT_PUSH     = 3'd0,
      ACT_READ     = 3'd1,
      ACT_READ_BIG = 3'd2,
      ACT_ALIGNED  = 3'd3,
      ACT_INIT     = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_SHORT = 2'd1,
      ST_ALIGN = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef logic [HALF_BITS-1:0] word_type;
   typedef word_type [MAX_POPS-1:0] head_array_type;

   typedef struct packed {
      logic             push;
      logic [POP_W-1:0] pops;
   } queue_ctl_type;

endpackage

`default_nettype wire

// ===== hdl/lzx_queue.sv =====
// Shift-register word queue: head always at entry 0, pops and a push per cycle.
// Depends on lzx_pkg.
`default_nettype none

module lzx_queue
   import lzx_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  queue_ctl_type     ctl,
   input  word_type          word,
   output logic [QCNT_W-1:0] count,
   output head_array_type    heads
);

   word_type [QUEUE_DEPTH-1:0] ent_ff, ent_in;
   logic [QCNT_W-1:0]          count_ff, count_in;

   assign count_in = count_ff + QCNT_W'(ctl.push) - QCNT_W'(ctl.pops);

   // shift down by the pop count, drop the new word in just above the survivors
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         ent_in[i] = ent_ff[i];
         for (int j = 0; j <= MAX_POPS; j++) begin
            if (ctl.pops == POP_W'(j)) begin
               if (ctl.push && (i + j) == int'(count_ff)) begin
                  ent_in[i] = word;
               end else if ((i + j) < QUEUE_DEPTH) begin
                  ent_in[i] = ent_ff[(i + j) % QUEUE_DEPTH];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   for (genvar m = 0; m < MAX_POPS; m++) begin : g_head
      if (m < QUEUE_DEPTH) begin : g_tap
         assign heads[m] = ent_ff[m];
      end else begin : g_none
         assign heads[m] = '0;
      end
   end

   assign count = count_ff;

endmodule

`default_nettype wire

// ===== hdl/lzx_step.sv =====
// Combinational datapath for one item: extract, refill and next-state logic.
// Depends on lzx_pkg.
`default_nettype none

module lzx_step
   import lzx_pkg::*;
(
   input  logic [2:0]        action,
   input  word_type          stream_word,
   input  logic [5:0]        bit_count,
   input  logic [31:0]       win,
   input  logic [POS_W-1:0]  cons,
   input  logic [QCNT_W-1:0] count,
   input  head_array_type    heads,
   output logic [31:0]       win_in,
   output logic [POS_W-1:0]  cons_in,
   output queue_ctl_type     qctl,
   output logic [31:0]       read_value,
   output logic [1:0]        status
);

   typedef struct packed {
      logic [31:0]      win;
      logic [POS_W-1:0] cons;
      logic [POP_W-1:0] qi;
   } wstate_type;

   typedef struct packed {
      logic        refused;
      logic [31:0] val;
      wstate_type  s;
   } take_type;

   // at most two words fit between two reads
   function automatic wstate_type refill(wstate_type s, head_array_type hv,
                                         logic [POP_W-1:0] avail);
      wstate_type r;
      r = s;
      for (int i = 0; i < 2; i++) begin
         if (r.cons >= POS_W'(HALF_BITS) && r.qi < avail) begin
            r.win  = {r.win[HALF_BITS-1:0], hv[r.qi[HEAD_W-1:0]]};
            r.cons = r.cons - POS_W'(HALF_BITS);
            r.qi   = r.qi + 1'b1;
         end
      end
      return r;
   endfunction

   function automatic take_type take(wstate_type s, logic [5:0] n, head_array_type hv,
                                     logic [POP_W-1:0] avail);
      take_type    t;
      logic [31:0] al;
      t.refused = 1'b0;
      t.val     = '0;
      t.s       = s;
      al        = '0;
      if (n != '0) begin
         if (n > POS_W'(WINDOW_BITS) - s.cons) begin
            t.refused = 1'b1;
         end else begin
            al       = s.win << s.cons;
            t.val    = al >> (POS_W'(WINDOW_BITS) - n);
            t.s.cons = s.cons + n;
            t.s      = refill(t.s, hv, avail);
         end
      end
      return t;
   endfunction

   logic              push_ok;
   logic [QCNT_W-1:0] keff;
   logic [POP_W-1:0]  avail;
   head_array_type    hv;
   wstate_type        s0, sn;
   take_type          t0, t1;
   logic [5:0]        n_sat, n0, n1;

   assign push_ok = (action_type'(action) == ACT_PUSH) && (count < QCNT_W'(QUEUE_DEPTH));
   assign keff    = count + QCNT_W'(push_ok);
   assign avail   = (int'(keff) >= MAX_POPS) ? POP_W'(MAX_POPS) : POP_W'(keff);

   // the pushed word sits just behind the queued ones
   always_comb begin
      for (int m = 0; m < MAX_POPS; m++) begin
         hv[m] = (push_ok && int'(count) == m) ? stream_word : heads[m];
      end
   end

   always_comb begin
      s0.win  = win;
      s0.cons = cons;
      s0.qi   = '0;
      sn      = s0;
      t0      = '0;
      t1      = '0;
      n_sat   = '0;
      n0      = '0;
      n1      = '0;
      read_value = '0;
      status     = ST_OK;
      case (action_type'(action))
         ACT_PUSH: begin
            if (!push_ok) begin
               status = ST_FULL;
            end else begin
               sn = refill(s0, hv, avail);
            end
         end
         ACT_READ: begin
            n_sat = (bit_count > 6'(SMALL_MAX)) ? 6'(SMALL_MAX) : bit_count;
            t0    = take(s0, n_sat, hv, avail);
            if (t0.refused) begin
               status = ST_SHORT;
            end else begin
               sn         = t0.s;
               read_value = t0.val;
            end
         end
         ACT_READ_BIG: begin
            n_sat = (bit_count > 6'(WINDOW_BITS)) ? 6'(WINDOW_BITS) : bit_count;
            n0    = n_sat >> 1;
            n1    = n_sat - n0;
            t0    = take(s0, n0, hv, avail);
            t1    = take(t0.s, n1, hv, avail);
            if (t0.refused || t1.refused) begin
               status = ST_SHORT;
            end else begin
               sn         = t1.s;
               read_value = (t0.val << n1) | t1.val;
            end
         end
         ACT_ALIGNED: begin
            if (cons != '0) begin
               status = ST_ALIGN;
            end else begin
               read_value = {win[HALF_BITS-1:0], win[31:HALF_BITS]};
               sn.cons    = POS_W'(WINDOW_BITS);
               sn         = refill(sn, hv, avail);
            end
         end
         ACT_INIT: begin
            sn.win  = '0;
            sn.cons = POS_W'(WINDOW_BITS);
            sn      = refill(sn, hv, avail);
         end
         default: begin
            sn = s0;
         end
      endcase
   end

   assign win_in    = sn.win;
   assign cons_in   = sn.cons;
   assign qctl.push = push_ok;
   assign qctl.pops = sn.qi;

endmodule

`default_nettype wire

// ===== hdl/lzx_bit_reader.sv =====
// Top level of the LZX-style bit reader: input register, datapath, result register.
// Depends on lzx_pkg, lzx_queue and lzx_step.
`default_nettype none

// The reader takes one request per clock while req_stall is low and returns
// exactly one response per request, in order. A request is registered on
// transfer, executed by the single-pass datapath (extract shifter, up to two
// word refills per read and the next-state logic for window, position and
// queue) once the result register can advance, and its response is registered
// at the same edge that commits the new state.
// The result register parts the two sides: a new request is taken while a
// finished response still waits, and req_stall rises only when both the input
// and result registers are full and rsp_stall is high. Words are pushed into a
// QUEUE_DEPTH-entry queue in front of the 32-bit window; a read is answered
// from the window and the window refills itself from the queue as bits are
// consumed. Reads that ask for more than the buffered bits, aligned reads with
// any window bit consumed and pushes into a full queue are refused with a status
// code and leave the state untouched.
module lzx_bit_reader
   import lzx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [15:0] req_stream_word,
   input  logic [5:0]  req_bit_count,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_read_value,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_bit_offset
);

   // input register
   logic              in_valid_ff, in_valid_in;
   logic [2:0]        action_ff;
   word_type          word_ff;
   logic [5:0]        count_req_ff;

   // reader state
   logic [31:0]       window_ff, window_in;
   logic [POS_W-1:0]  cons_ff, cons_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_read_value_ff;
   logic [1:0]        rsp_status_ff;
   logic [3:0]        rsp_bit_offset_ff;

   logic              advance, fire, req_take;
   queue_ctl_type     qctl;
   logic [QCNT_W-1:0] q_count;
   head_array_type    q_heads;
   logic [31:0]       step_value;
   logic [1:0]        step_status;

   // the result register frees up when empty or when its transfer completes
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = fire ? 1'b1 : (rsp_valid_ff && rsp_stall);

   lzx_queue u_queue (
      .clock (clock),
      .reset (reset),
      .ctl   (fire ? qctl : queue_ctl_type'('0)),
      .word  (word_ff),
      .count (q_count),
      .heads (q_heads)
   );

   lzx_step u_step (
      .action      (action_ff),
      .stream_word (word_ff),
      .bit_count   (count_req_ff),
      .win         (window_ff),
      .cons        (cons_ff),
      .count       (q_count),
      .heads       (q_heads),
      .win_in      (window_in),
      .cons_in     (cons_in),
      .qctl        (qctl),
      .read_value  (step_value),
      .status      (step_status)
   );

   // control and reader state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         window_ff    <= '0;
         cons_ff      <= POS_W'(WINDOW_BITS);
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            window_ff <= window_in;
            cons_ff   <= cons_in;
         end
      end
   end

   // payload: capture on transfer, hold while stalled
   always_ff @(posedge clock) begin
      if (req_take) begin
         action_ff    <= req_action;
         word_ff      <= req_stream_word;
         count_req_ff <= req_bit_count;
      end
      if (fire) begin
         rsp_read_value_ff <= step_value;
         rsp_status_ff     <= step_status;
         rsp_bit_offset_ff <= cons_in[3:0];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_bit_offset = rsp_bit_offset_ff;

   // the refill never leaves a whole free half-word while words wait in the queue
   assert property (@(posedge clock) disable iff (reset)
      !(cons_ff >= POS_W'(HALF_BITS) && q_count != '0))
      else $error("window left short while queue holds words");

   assert property (@(posedge clock) disable iff (reset)
      cons_ff <= POS_W'(WINDOW_BITS) && q_count <= QCNT_W'(QUEUE_DEPTH))
      else $error("position or queue count out of range");

   // a committed step reports the position it leaves behind
   assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff && rsp_bit_offset_ff == cons_ff[3:0])
      else $error("response offset disagrees with committed position");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for lzx_bit_reader: drives request transfers with random gaps,
// predicts each response from its own window/queue model and checks responses in order.
// Depends on lzx_pkg and the lzx_bit_reader RTL.
`default_nettype none

module tb;
   import lzx_pkg::*;

   // Bench-side view of the reader: window, consumed position, queued words.
   // words[0] is always the oldest queued word.
   typedef struct packed {
      logic [31:0]                          window;
      logic [POS_W-1:0]                     used;
      logic [QUEUE_DEPTH-1:0][HALF_BITS-1:0] words;
      logic [QCNT_W-1:0]                    count;
   } bench_state_type;

   typedef struct packed {
      logic [31:0] value;
      status_type  status;
      logic [3:0]  offset;
   } response_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_action = 3'd0;
   logic [15:0] req_stream_word = 16'd0;
   logic [5:0]  req_bit_count = 6'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_read_value;
   logic [1:0]  rsp_status;
   logic [3:0]  rsp_bit_offset;

   bench_state_type model;
   response_type    pending_responses[$];
   int              fault_count = 0;
   bit              tx_quiet = 1'b0;
   bit              rx_quiet = 1'b0;
   int              hold_cycles = 0;
   int              stall_left = 0;

   lzx_bit_reader u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_stream_word (req_stream_word),
      .req_bit_count   (req_bit_count),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_read_value  (rsp_read_value),
      .rsp_status      (rsp_status),
      .rsp_bit_offset  (rsp_bit_offset)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Generous fixed limit: far beyond the slowest legal run.
   initial begin
      #4000000;
      $display("TB_ERROR");
      $finish;
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // Shift queued words into the window while a whole half is consumed.
   function automatic bench_state_type refill_window(input bench_state_type s);
      while (s.used >= HALF_BITS && s.count != 0) begin
         s.window = {s.window[HALF_BITS-1:0], s.words[0]};
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) s.words[i] = s.words[i+1];
         s.count = s.count - 1'b1;
         s.used  = POS_W'(s.used - HALF_BITS);
      end
      return s;
   endfunction

   // Take n bits from the top of the unconsumed part; refill on success.
   function automatic status_type take_bits(inout bench_state_type s, input int unsigned n,
                                            output logic [31:0] val);
      logic [63:0] aligned;
      int unsigned avail;
      avail = WINDOW_BITS - s.used;
      val = 32'd0;
      if (n == 0) return ST_OK;
      if (n > avail) return ST_SHORT;
      aligned = {32'd0, s.window} << s.used;
      val = aligned[31:0] >> (WINDOW_BITS - n);
      s.used = POS_W'(s.used + n);
      s = refill_window(s);
      return ST_OK;
   endfunction

   // Advance the model by one request and return the response it must produce.
   function automatic response_type predict_response(input logic [2:0] act,
                                                     input logic [15:0] word,
                                                     input logic [5:0] cnt);
      response_type    rsp;
      bench_state_type trial;
      int unsigned     n, n0, n1;
      logic [31:0]     v0, v1;
      logic [63:0]     joined;
      rsp.value  = 32'd0;
      rsp.status = ST_OK;
      n = 32'(cnt);
      case (act)
         ACT_PUSH: begin
            if (model.count >= QUEUE_DEPTH) begin
               rsp.status = ST_FULL;
            end else begin
               model.words[model.count[$clog2(QUEUE_DEPTH)-1:0]] = word;
               model.count = model.count + 1'b1;
               model = refill_window(model);
            end
         end
         ACT_READ: begin
            if (n > SMALL_MAX) n = SMALL_MAX;
            rsp.status = take_bits(model, n, rsp.value);
         end
         ACT_READ_BIG: begin
            // Serve both halves on a copy; commit only if neither is refused.
            if (n > WINDOW_BITS) n = WINDOW_BITS;
            n0 = n / 2;
            n1 = n - n0;
            trial = model;
            rsp.status = take_bits(trial, n0, v0);
            if (rsp.status == ST_OK) rsp.status = take_bits(trial, n1, v1);
            if (rsp.status == ST_OK) begin
               model = trial;
               joined = ({32'd0, v0} << n1) + {32'd0, v1};
               rsp.value = joined[31:0];
            end
         end
         ACT_ALIGNED: begin
            if (model.used != 0) begin
               rsp.status = ST_ALIGN;
            end else begin
               rsp.value = {model.window[15:0], model.window[31:16]};
               model.used = POS_W'(WINDOW_BITS);
               model = refill_window(model);
            end
         end
         ACT_INIT: begin
            model.window = 32'd0;
            model.used = POS_W'(WINDOW_BITS);
            model = refill_window(model);
         end
         default: ;
      endcase
      rsp.offset = model.used[3:0];
      return rsp;
   endfunction

   // ------------------------------------------------------------------
   // Driving
   // ------------------------------------------------------------------

   // Mostly back to back, sometimes a short gap, rarely a long one.
   function automatic int pick_gap(input bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(3, 1);
      return $urandom_range(30, 8);
   endfunction

   function automatic logic [15:0] pick_word();
      int r;
      r = $urandom_range(9);
      if (r == 0) return 16'h0000;
      if (r == 1) return 16'hFFFF;
      return 16'($urandom);
   endfunction

   // Offer one request, hold it until the transfer, then predict its response.
   task automatic send_item(input logic [2:0] act, input logic [15:0] word,
                            input logic [5:0] cnt);
      int gap;
      if (!req_valid) req_valid <= 1'b1;
      req_action      <= act;
      req_stream_word <= word;
      req_bit_count   <= cnt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_responses.push_back(predict_response(act, word, cnt));
      gap = pick_gap(tx_quiet);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and pause until every predicted response has come back.
   task automatic wait_drained();
      if (req_valid) req_valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
   endtask

   // Pick a request that keeps the stream well formed most of the time:
   // push while there is room, read no more than is buffered, rare noise.
   task automatic send_stream_item();
      int          r;
      int unsigned avail;
      r = $urandom_range(99);
      avail = WINDOW_BITS - model.used;
      if (r < 8) begin
         send_item(3'($urandom_range(7)), 16'($urandom), 6'($urandom_range(63)));
      end else if (r < 12) begin
         send_item(ACT_INIT, pick_word(), 6'($urandom_range(63)));
      end else if (r < 17) begin
         send_item(ACT_ALIGNED, pick_word(), 6'($urandom_range(63)));
      end else if (model.count < QUEUE_DEPTH && (avail < SMALL_MAX || r < 45)) begin
         send_item(ACT_PUSH, pick_word(), 6'($urandom_range(63)));
      end else if (r < 70) begin
         send_item(ACT_READ, pick_word(),
                   6'($urandom_range((avail < SMALL_MAX) ? ((avail == 0) ? 1 : avail)
                                                          : SMALL_MAX, 1)));
      end else begin
         send_item(ACT_READ_BIG, pick_word(),
                   6'($urandom_range((avail == 0) ? 1 : avail, 1)));
      end
   endtask

   // ------------------------------------------------------------------
   // Response side: check each transfer, then choose the next stall
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      response_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_responses.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("unexpected response: value %h status %0d offset %0d",
                        rsp_read_value, rsp_status, rsp_bit_offset);
         end else begin
            want = pending_responses.pop_front();
            if (rsp_read_value !== want.value || rsp_status !== want.status ||
                rsp_bit_offset !== want.offset) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("mismatch: expected value %h status %0d offset %0d, got %h %0d %0d",
                           want.value, want.status, want.offset,
                           rsp_read_value, rsp_status, rsp_bit_offset);
            end
         end
      end
      // A requested hold takes precedence over the random stall pattern.
      if (hold_cycles != 0) begin
         stall_left = hold_cycles;
         hold_cycles = 0;
      end else if (stall_left != 0) begin
         stall_left--;
      end else begin
         stall_left = pick_gap(rx_quiet);
      end
      rsp_stall <= (stall_left != 0);
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Every action, count extremes and each refused or saturated case.
   task automatic test_directed();
      tx_quiet = 1'b0;
      send_item(ACT_READ, 16'h0000, 6'd1);         // empty window: too few bits
      send_item(ACT_ALIGNED, 16'h0000, 6'd0);      // window not whole: off alignment
      send_item(ACT_READ, 16'hFFFF, 6'd0);         // zero-bit read
      send_item(ACT_READ_BIG, 16'hFFFF, 6'd0);     // zero-bit big read
      send_item(ACT_PUSH, 16'h0000, 6'd63);
      send_item(ACT_PUSH, 16'hFFFF, 6'd0);         // window now whole
      send_item(ACT_ALIGNED, 16'h0000, 6'd32);     // halves swapped, window emptied
      send_item(ACT_PUSH, 16'hA5C3, 6'd0);
      send_item(ACT_PUSH, 16'h3C5A, 6'd0);
      send_item(ACT_PUSH, 16'hFFFF, 6'd0);
      send_item(ACT_PUSH, 16'h0001, 6'd0);
      send_item(ACT_PUSH, 16'h8000, 6'd0);
      send_item(ACT_PUSH, 16'h1234, 6'd0);         // queue full
      send_item(ACT_PUSH, 16'hFFFF, 6'd0);         // dropped: queue full
      send_item(ACT_READ, 16'h0000, 6'd63);        // saturates to the small maximum
      send_item(ACT_READ_BIG, 16'h0000, 6'd63);    // saturates to a full window
      send_item(ACT_READ_BIG, 16'h0000, 6'd31);    // odd split
      send_item(ACT_READ_BIG, 16'h0000, 6'd32);    // second half short: refused whole
      send_item(ACT_READ, 16'h0000, 6'd17);        // too few bits
      send_item(ACT_READ, 16'h0000, 6'd16);
      send_item(ACT_PUSH, 16'h0F0F, 6'd0);
      send_item(ACT_PUSH, 16'hF0F0, 6'd0);
      send_item(ACT_PUSH, 16'h1111, 6'd0);
      send_item(ACT_INIT, 16'h0000, 6'd0);         // clear window, refill from queue
      send_item(ACT_READ, 16'h0000, 6'd1);
      send_item(3'd5, 16'hFFFF, 6'd63);            // unused actions
      send_item(3'd6, 16'h0000, 6'd0);
      send_item(3'd7, 16'h5555, 6'd42);
      wait_drained();
   endtask

   // Long well-formed streams, with randomly chosen quiet and gappy stretches.
   task automatic test_random_stream();
      for (int i = 0; i < 450; i++) begin
         if (i % 64 == 0) begin
            tx_quiet = ($urandom_range(3) == 0);
            rx_quiet = ($urandom_range(3) == 0);
         end
         send_stream_item();
      end
      tx_quiet = 1'b0;
      rx_quiet = 1'b0;
      wait_drained();
   endtask

   // Hold the response side off while requests keep coming, so the block fills up.
   task automatic test_backpressure();
      tx_quiet = 1'b1;
      hold_cycles = 80;
      for (int i = 0; i < 40; i++) send_stream_item();
      tx_quiet = 1'b0;
      wait_drained();
   endtask

   // Unshaped requests: any action, any word, any count.
   task automatic test_random_noise();
      for (int i = 0; i < 100; i++)
         send_item(3'($urandom_range(7)), 16'($urandom), 6'($urandom_range(63)));
      wait_drained();
   endtask

   initial begin
      model.window = 32'd0;
      model.used   = POS_W'(WINDOW_BITS);
      model.words  = '0;
      model.count  = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_stream();
      test_backpressure();
      test_random_noise();
      // Let any stray response surface before the verdict.
      repeat (8) @(posedge clock);
      if (fault_count == 0 && pending_responses.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/lzx_pkg.sv
hdl/lzx_queue.sv
hdl/lzx_step.sv
hdl/lzx_bit_reader.sv
bench/tb.sv
